@@ design/trfrb_pkg.sv @@
// Shared types and constants for the two-run frame reorder buffer.
// Used by the controller, the datapath, the top level and the checker.
`default_nettype none
package trfrb_pkg;

  localparam int TABLE_SIZE_DEFAULT  = 1024;
  localparam int HANDLE_BITS_DEFAULT = 16;
  localparam int INTERVAL_W          = 11;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 11'd6;

  localparam logic       OP_FRAME = 1'b0;
  localparam logic       OP_TICK  = 1'b1;

  localparam logic [1:0] OUTCOME_STORED  = 2'd0;
  localparam logic [1:0] OUTCOME_DROPPED = 2'd1;
  localparam logic [1:0] OUTCOME_TICK    = 2'd2;

  typedef struct packed {
    logic        opcode;
    logic [31:0] sequence_number;
    logic [15:0] run_number;
    logic [15:0] frame_handle;
  } in_t;

  typedef struct packed {
    logic [1:0]  outcome;
    logic        released;
    logic        release_missed;
    logic [31:0] released_sequence;
    logic [15:0] released_handle;
    logic        released_table;
  } out_t;

  typedef struct packed {
    logic clr;
    logic latch;
    logic div_tot;
    logic div_step;
    logic slot_read;
    logic store;
    logic set_drop;
    logic rel_setup;
    logic scan;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_done;
    logic rem_zero;
    logic rd_valid;
    logic op_tick;
    logic any_stored;
    logic interval_zero;
    logic scan_end;
  } stat_t;

endpackage
`default_nettype wire

@@ design/trfrb_controller.sv @@
// Sequencer for the reorder buffer: clearing pass, slot index, store,
// interval check, release scan and result hand-off. Uses trfrb_pkg.
`default_nettype none
module trfrb_controller (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  wire logic           out_stall,
  input  wire trfrb_pkg::stat_t stat,
  output trfrb_pkg::cmd_t     cmd
);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_MODSEQ = 4'd2;
  localparam logic [3:0] S_CHKSLT = 4'd3;
  localparam logic [3:0] S_TOTST  = 4'd4;
  localparam logic [3:0] S_MODTOT = 4'd5;
  localparam logic [3:0] S_RELSET = 4'd6;
  localparam logic [3:0] S_SCAN   = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else     state <= state_next;
  end

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          if (!stat.op_tick)        state_next = S_MODSEQ;
          else if (stat.any_stored) state_next = S_RELSET;
          else                      state_next = S_OUT;
        end
      end
      S_MODSEQ: begin
        if (stat.div_done) begin
          cmd.slot_read = 1'b1;
          state_next    = S_CHKSLT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_CHKSLT: begin
        if (stat.rd_valid) begin
          cmd.set_drop = 1'b1;
          state_next   = S_OUT;
        end else begin
          cmd.store  = 1'b1;
          state_next = stat.interval_zero ? S_OUT : S_TOTST;
        end
      end
      S_TOTST: begin
        cmd.div_tot = 1'b1;
        state_next  = S_MODTOT;
      end
      S_MODTOT: begin
        if (stat.div_done) state_next = stat.rem_zero ? S_RELSET : S_OUT;
        else               cmd.div_step = 1'b1;
      end
      S_RELSET: begin
        cmd.rel_setup = 1'b1;
        state_next    = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_end) state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule
`default_nettype wire

@@ design/trfrb_datapath.sv @@
// Datapath: slot memory, per-run counts and last-sent numbers, a reciprocal
// slot-index unit, a serial remainder unit for the interval check, the release
// scan and the result word. Uses trfrb_pkg.
`default_nettype none
module trfrb_datapath #(
  parameter int TABLE_SIZE  = trfrb_pkg::TABLE_SIZE_DEFAULT,
  parameter int HANDLE_BITS = trfrb_pkg::HANDLE_BITS_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire trfrb_pkg::in_t                  in_data,
  input  wire logic                            cfg_we,
  input  wire logic [trfrb_pkg::INTERVAL_W-1:0] cfg_data,
  input  wire trfrb_pkg::cmd_t                 cmd,
  output trfrb_pkg::stat_t                     stat,
  output trfrb_pkg::out_t                      out_data
);

  localparam int IDXW  = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int AW    = $clog2(2 * TABLE_SIZE);
  localparam int CW    = $clog2(TABLE_SIZE + 1);
  localparam int DVW   = (CW > trfrb_pkg::INTERVAL_W) ? CW : trfrb_pkg::INTERVAL_W;
  localparam int WW    = 1 + 32 + HANDLE_BITS;
  localparam int DEPTH = 2 * TABLE_SIZE;

  // reciprocal of TABLE_SIZE, exact for every 32-bit sequence number
  localparam int          SH     = $clog2(TABLE_SIZE);
  localparam logic [64:0] RECIP  = ((65'd1 << (32 + SH)) / 65'(TABLE_SIZE)) + 65'd1;
  localparam logic [16:0] REC_LO = RECIP[16:0];
  localparam logic [15:0] REC_HI = RECIP[32:17];

  logic [trfrb_pkg::INTERVAL_W-1:0] interval;
  trfrb_pkg::in_t  item;
  trfrb_pkg::out_t result;
  logic            act;
  logic [15:0]     prev_run;
  logic [CW-1:0]   count [2];
  logic [31:0]     last  [2];

  logic [31:0]     dvd;
  logic [DVW-1:0]  dvs;
  logic [DVW-1:0]  rem;
  logic [5:0]      dcnt;
  logic [DVW:0]    rem2;
  logic [DVW:0]    rem_sub;

  logic            seq_mode;
  logic [2:0]      mstep;
  logic [48:0]     prod_lo;
  logic [47:0]     prod_hi;
  logic [64:0]     qsum;
  logic [31:0]     quo;
  logic [48:0]     qt;

  logic [WW-1:0]   mem [DEPTH];
  logic [WW-1:0]   rdata;
  logic [AW-1:0]   clr_addr;
  logic [AW-1:0]   slot_addr;
  logic [AW-1:0]   waddr, raddr;
  logic [WW-1:0]   wdata;
  logic            we, re;

  logic            pick;
  logic [IDXW:0]   scan_idx;
  logic            chk_valid;
  logic [IDXW-1:0] chk_idx;

  logic            rd_valid;
  logic [31:0]     rd_seq;
  logic [HANDLE_BITS-1:0] rd_handle;
  logic            hit, miss;
  logic [CW:0]     total;

  function automatic logic [AW-1:0] slot_at(input logic tbl, input logic [IDXW-1:0] idx);
    slot_at = (tbl ? AW'(TABLE_SIZE) : AW'(0)) + AW'(idx);
  endfunction

  assign rd_valid  = rdata[WW-1];
  assign rd_seq    = rdata[WW-2 -: 32];
  assign rd_handle = rdata[HANDLE_BITS-1:0];
  assign hit  = chk_valid && rd_valid && (last[pick] < rd_seq);
  assign miss = chk_valid && !hit && (chk_idx == IDXW'(TABLE_SIZE - 1));
  assign total = {1'b0, count[0]} + {1'b0, count[1]};

  // one restoring remainder step per cycle
  assign rem2    = {rem, dvd[31]};
  assign rem_sub = rem2 - {1'b0, dvs};

  assign qsum = {16'd0, prod_lo} + {prod_hi, 17'd0};

  assign stat.clr_last      = (clr_addr == AW'(DEPTH - 1));
  assign stat.div_done      = seq_mode ? (mstep == 3'd5) : (dcnt == 6'd32);
  assign stat.rem_zero      = (rem == '0);
  assign stat.rd_valid      = rd_valid;
  assign stat.op_tick       = (in_data.opcode == trfrb_pkg::OP_TICK);
  assign stat.any_stored    = (count[0] != '0) || (count[1] != '0);
  assign stat.interval_zero = (interval == '0);
  assign stat.scan_end      = hit || miss;

  assign out_data = result;

  always_comb begin
    we    = 1'b0;
    waddr = clr_addr;
    wdata = '0;
    if (cmd.clr) begin
      we = 1'b1;
    end else if (cmd.store) begin
      we    = 1'b1;
      waddr = slot_addr;
      wdata = {1'b1, item.sequence_number, HANDLE_BITS'(item.frame_handle)};
    end else if (cmd.scan && hit) begin
      we    = 1'b1;
      waddr = slot_at(pick, chk_idx);
    end
  end

  always_comb begin
    if (cmd.slot_read) begin
      raddr = slot_at(act, rem[IDXW-1:0]);
      re    = 1'b1;
    end else begin
      raddr = slot_at(pick, scan_idx[IDXW-1:0]);
      re    = cmd.scan && !hit && !miss && (scan_idx < (IDXW+1)'(TABLE_SIZE));
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      interval  <= trfrb_pkg::INTERVAL_RESET;
      act       <= 1'b0;
      prev_run  <= '0;
      count[0]  <= '0;
      count[1]  <= '0;
      last[0]   <= '0;
      last[1]   <= '0;
      clr_addr  <= '0;
      chk_valid <= 1'b0;
      dcnt      <= '0;
      seq_mode  <= 1'b0;
      mstep     <= '0;
    end else begin
      if (cfg_we) interval <= cfg_data;
      if (cmd.clr) clr_addr <= clr_addr + AW'(1);

      if (cmd.latch) begin
        dvd      <= in_data.sequence_number;
        rem      <= '0;
        dcnt     <= '0;
        mstep    <= '0;
        seq_mode <= 1'b1;
        if (in_data.opcode == trfrb_pkg::OP_FRAME) begin
          // a nonzero run that changes flips the active table
          if (prev_run != '0 && prev_run != in_data.run_number) act <= ~act;
          prev_run <= in_data.run_number;
        end
      end
      if (cmd.div_tot) begin
        dvd      <= 32'(total);
        dvs      <= DVW'(interval);
        rem      <= '0;
        dcnt     <= '0;
        seq_mode <= 1'b0;
      end
      if (cmd.div_step) begin
        if (seq_mode) begin
          // slot index: quotient by reciprocal, then sequence minus quotient times size
          mstep <= mstep + 3'd1;
          case (mstep)
            3'd0:    prod_lo <= {17'd0, dvd} * {32'd0, REC_LO};
            3'd1:    prod_hi <= {16'd0, dvd} * {32'd0, REC_HI};
            3'd2:    quo     <= 32'(qsum >> (32 + SH));
            3'd3:    qt      <= {17'd0, quo} * 49'(TABLE_SIZE);
            3'd4:    rem     <= DVW'(dvd - qt[31:0]);
            default: ;
          endcase
        end else begin
          rem  <= rem_sub[DVW] ? rem2[DVW-1:0] : rem_sub[DVW-1:0];
          dvd  <= {dvd[30:0], 1'b0};
          dcnt <= dcnt + 6'd1;
        end
      end

      if (cmd.store) count[act] <= count[act] + CW'(1);

      if (cmd.rel_setup) begin
        chk_valid <= 1'b0;
        if (count[~act] != '0) begin
          pick <= ~act;
        end else begin
          pick       <= act;
          last[~act] <= '0;
        end
      end

      if (cmd.scan) begin
        if (hit) begin
          last[pick] <= rd_seq;
          if (count[pick] != '0) count[pick] <= count[pick] - CW'(1);
          chk_valid <= 1'b0;
        end else if (!miss) begin
          chk_valid <= re;
        end else begin
          chk_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.slot_read) slot_addr <= raddr;
    if (cmd.rel_setup) scan_idx <= '0;
    if (cmd.scan && re) begin
      chk_idx  <= scan_idx[IDXW-1:0];
      scan_idx <= scan_idx + (IDXW+1)'(1);
    end
    if (cmd.latch) begin
      item   <= in_data;
      result <= {(in_data.opcode == trfrb_pkg::OP_TICK) ?
                 trfrb_pkg::OUTCOME_TICK : trfrb_pkg::OUTCOME_STORED, 51'd0};
    end
    if (cmd.set_drop) result.outcome <= trfrb_pkg::OUTCOME_DROPPED;
    if (cmd.scan && hit)
      result <= {result.outcome, 1'b1, 1'b0, rd_seq, 16'(rd_handle), pick};
    if (cmd.scan && miss) result.release_missed <= 1'b1;
  end

endmodule
`default_nettype wire

@@ design/two_run_frame_reorder_buffer.sv @@
// Top level of the two-run frame reorder buffer: controller plus datapath.
// Depends on trfrb_pkg, trfrb_controller and trfrb_datapath.
//
//   channel  direction  handshake            word
//   in       input      in_valid/in_stall    trfrb_pkg::in_t
//   out      output     out_valid/out_stall  trfrb_pkg::out_t
//   cfg      input      cfg_valid/cfg_ready  release_interval, 11 bits
//
// One item at a time. An arrival passes the slot index, the slot check and,
// with a nonzero interval, the interval check; a release adds a setup state
// and a slot scan, one memory read per cycle. A tick goes straight to the
// result, or through the release when frames are stored. Each item ends in
// the result state and then returns to idle. After reset a clearing pass
// empties all 2 * TABLE_SIZE slots; input stalls meanwhile. Configuration
// writes are taken at any time. A stalled result holds until taken; the
// next word is accepted after that.
`default_nettype none
module two_run_frame_reorder_buffer #(
  parameter int TABLE_SIZE  = trfrb_pkg::TABLE_SIZE_DEFAULT,
  parameter int HANDLE_BITS = trfrb_pkg::HANDLE_BITS_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire trfrb_pkg::in_t                   in_data,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output trfrb_pkg::out_t                       out_data,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [trfrb_pkg::INTERVAL_W-1:0] cfg_data
);

  trfrb_pkg::cmd_t  cmd;
  trfrb_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  trfrb_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  trfrb_datapath #(
    .TABLE_SIZE  (TABLE_SIZE),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

@@ design/trfrb_checker.sv @@
// Port-level checks for the two-run frame reorder buffer, bound to the top.
// Depends on trfrb_pkg.
`default_nettype none
module trfrb_checker (
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            in_stall,
  input wire logic            out_valid,
  input wire logic            out_stall,
  input wire trfrb_pkg::out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while a result is pending");

  a_rel_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.released && out_data.release_missed))
    else $error("released and missed together");

  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.released |->
      out_data.released_sequence == 32'd0 && out_data.released_handle == 16'd0 &&
      out_data.released_table == 1'b0)
    else $error("release fields not zero");

  a_drop_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.outcome == trfrb_pkg::OUTCOME_DROPPED |->
      !out_data.released && !out_data.release_missed)
    else $error("dropped frame caused a release");

endmodule

bind two_run_frame_reorder_buffer trfrb_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
